@@ hw/rtl/shcd_pkg.sv @@
// shcd_pkg: shared types, codes and CRC16 helpers for the sync/header/CRC deframer.
// No dependencies; used by every module under hw/rtl.
package shcd_pkg;

    localparam int          QUEUE_DEPTH   = 4;
    localparam int          HEADER_BYTES  = 11;
    localparam logic [15:0] MAX_LEN_RESET = 16'd1024;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [7:0]  SYNC_BYTE     = 8'hFF;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEADER,
        PH_PAYLOAD,
        PH_CRC
    } t_phase;

    // what the front tells the back about one queued beat
    typedef enum logic [1:0] {
        CLS_PAYLOAD,
        CLS_CLOSE,
        CLS_LEN_ERR
    } t_cls;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_CRC_ERR = 2'd2,
        KIND_LEN_ERR = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0]  device_type;
        logic [31:0] device_id;
        logic [15:0] command_id;
        logic [15:0] message_id;
        logic [15:0] payload_len;
    } t_hdr;

    typedef struct packed {
        t_cls        cls;
        logic [7:0]  data;
        t_hdr        hdr;
        logic [15:0] crc_calc;
        logic [15:0] crc_recv;
    } t_entry;

    // Modbus CRC16, one byte, reflected
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // CRC state after n sync bytes, n at most 7; elaboration-time only
    function automatic logic [15:0] sync_crc(input int n);
        logic [15:0] c;
        c = CRC_INIT;
        for (int k = 0; k < 7; k++) begin
            if (k < n) begin
                c = crc_byte(c, SYNC_BYTE);
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/shcd_front.sv @@
// shcd_front: sync hunt, header parse and CRC accumulation; one queue entry per result.
// Depends on shcd_pkg.
module shcd_front #(
    parameter int SYNC_LEN = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic [15:0]       i_max_len,
    output logic              o_push,
    output shcd_pkg::t_entry  o_entry
);

    localparam int          RUN_W    = (SYNC_LEN > 1) ? $clog2(SYNC_LEN) : 1;
    localparam logic [15:0] SYNC_CRC = shcd_pkg::sync_crc(SYNC_LEN);
    localparam logic [15:0] HDR_LAST = 16'(shcd_pkg::HEADER_BYTES - 1);

    shcd_pkg::t_phase r_phase, n_phase;
    logic [RUN_W-1:0] r_run,   n_run;
    logic [15:0]      r_count, n_count;
    logic [15:0]      r_crc,   n_crc;
    logic [7:0]       r_type,  n_type;
    logic [63:0]      r_shift, n_shift;
    logic [15:0]      r_len,   n_len;
    logic [7:0]       r_crc_hi, n_crc_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= shcd_pkg::PH_HUNT;
            r_run   <= '0;
            r_count <= '0;
            r_crc   <= shcd_pkg::CRC_INIT;
        end else begin
            r_phase <= n_phase;
            r_run   <= n_run;
            r_count <= n_count;
            r_crc   <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type   <= n_type;
        r_shift  <= n_shift;
        r_len    <= n_len;
        r_crc_hi <= n_crc_hi;
    end

    always_comb begin
        n_phase  = r_phase;
        n_run    = r_run;
        n_count  = r_count;
        n_crc    = r_crc;
        n_type   = r_type;
        n_shift  = r_shift;
        n_len    = r_len;
        n_crc_hi = r_crc_hi;
        o_push   = 1'b0;
        o_entry.cls      = shcd_pkg::CLS_PAYLOAD;
        o_entry.data     = i_byte;
        o_entry.crc_calc = r_crc;
        o_entry.crc_recv = {r_crc_hi, i_byte};
        if (i_valid) begin
            unique case (r_phase)
                shcd_pkg::PH_HUNT: begin
                    if (i_byte == shcd_pkg::SYNC_BYTE) begin
                        if (r_run == RUN_W'(SYNC_LEN - 1)) begin
                            n_phase = shcd_pkg::PH_HEADER;
                            n_run   = '0;
                            n_count = '0;
                            n_crc   = SYNC_CRC;
                        end else begin
                            n_run = r_run + 1'b1;
                        end
                    end else begin
                        n_run = '0;
                    end
                end
                shcd_pkg::PH_HEADER: begin
                    n_crc   = shcd_pkg::crc_byte(r_crc, i_byte);
                    n_count = r_count + 16'd1;
                    priority if (r_count == 16'd0) begin
                        n_type = i_byte;
                    end else if (r_count <= 16'd8) begin
                        n_shift = {r_shift[55:0], i_byte};
                    end else if (r_count == 16'd9) begin
                        n_len = {i_byte, 8'h00};
                    end else begin
                        n_len = {r_len[15:8], i_byte};
                    end
                    if (r_count == HDR_LAST) begin
                        n_count = '0;
                        if (n_len > i_max_len) begin
                            o_push      = 1'b1;
                            o_entry.cls = shcd_pkg::CLS_LEN_ERR;
                            n_phase     = shcd_pkg::PH_HUNT;
                            n_run       = '0;
                        end else if (n_len == 16'd0) begin
                            n_phase = shcd_pkg::PH_CRC;
                        end else begin
                            n_phase = shcd_pkg::PH_PAYLOAD;
                        end
                    end
                end
                shcd_pkg::PH_PAYLOAD: begin
                    n_crc       = shcd_pkg::crc_byte(r_crc, i_byte);
                    o_push      = 1'b1;
                    o_entry.cls = shcd_pkg::CLS_PAYLOAD;
                    if (({1'b0, r_count} + 17'd1) >= {1'b0, r_len}) begin
                        n_count = '0;
                        n_phase = shcd_pkg::PH_CRC;
                    end else begin
                        n_count = r_count + 16'd1;
                    end
                end
                shcd_pkg::PH_CRC: begin
                    if (r_count == 16'd0) begin
                        n_crc_hi = i_byte;
                        n_count  = 16'd1;
                    end else begin
                        o_push      = 1'b1;
                        o_entry.cls = shcd_pkg::CLS_CLOSE;
                        n_phase     = shcd_pkg::PH_HUNT;
                        n_count     = '0;
                        n_run       = '0;
                    end
                end
                default: begin
                    n_phase = shcd_pkg::PH_HUNT;
                end
            endcase
        end
        // header as it stands after this beat
        o_entry.hdr.device_type = n_type;
        o_entry.hdr.device_id   = n_shift[63:32];
        o_entry.hdr.command_id  = n_shift[31:16];
        o_entry.hdr.message_id  = n_shift[15:0];
        o_entry.hdr.payload_len = n_len;
    end

endmodule

@@ hw/rtl/shcd_queue.sv @@
// shcd_queue: short FIFO of classified beats between front and back.
// Depends on shcd_pkg.
module shcd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  shcd_pkg::t_entry  i_entry,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_nonempty,
    output shcd_pkg::t_entry  o_head
);

    localparam int PTR_W = $clog2(shcd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    shcd_pkg::t_entry r_mem [shcd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_pop  ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    assign o_full     = (r_cnt == CNT_W'(shcd_pkg::QUEUE_DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_head     = r_mem[r_rd];

endmodule

@@ hw/rtl/shcd_back.sv @@
// shcd_back: output register; resolves the CRC verdict and formats each result beat.
// Depends on shcd_pkg.
module shcd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  shcd_pkg::t_entry  i_entry,
    output logic              o_pop,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [1:0]        o_result_kind,
    output logic [7:0]        o_payload_byte,
    output shcd_pkg::t_hdr    o_hdr,
    output logic [15:0]       o_received_crc,
    output logic              o_frame_last
);

    logic              r_valid;
    shcd_pkg::t_kind   r_kind,  n_kind;
    logic [7:0]        r_data,  n_data;
    shcd_pkg::t_hdr    r_hdr;
    logic [15:0]       r_crc,   n_crc;
    logic              r_last,  n_last;
    logic              load;

    assign load  = !r_valid || !i_stall;
    assign o_pop = load && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= n_kind;
            r_data <= n_data;
            r_hdr  <= i_entry.hdr;
            r_crc  <= n_crc;
            r_last <= n_last;
        end
    end

    always_comb begin
        n_kind = shcd_pkg::KIND_PAYLOAD;
        n_data = 8'h00;
        n_crc  = 16'h0000;
        n_last = 1'b0;
        unique case (i_entry.cls)
            shcd_pkg::CLS_PAYLOAD: begin
                n_data = i_entry.data;
            end
            shcd_pkg::CLS_CLOSE: begin
                n_kind = (i_entry.crc_recv == i_entry.crc_calc) ? shcd_pkg::KIND_GOOD
                                                                : shcd_pkg::KIND_CRC_ERR;
                n_crc  = i_entry.crc_recv;
                n_last = 1'b1;
            end
            shcd_pkg::CLS_LEN_ERR: begin
                n_kind = shcd_pkg::KIND_LEN_ERR;
                n_last = 1'b1;
            end
            default: begin
                n_data = i_entry.data;
            end
        endcase
    end

    assign o_valid        = r_valid;
    assign o_result_kind  = r_kind;
    assign o_payload_byte = r_data;
    assign o_hdr          = r_hdr;
    assign o_received_crc = r_crc;
    assign o_frame_last   = r_last;

endmodule

@@ hw/rtl/sync_header_crc_frame_deframer.sv @@
// Channel   Dir  Handshake                     Beat
// rx        in   i_rx_valid / o_rx_stall       one received byte
// result    out  o_res_valid / i_res_stall     payload byte or frame verdict with header
// cfg       in   i_cfg_valid / o_cfg_ready     max_payload_len
//
// One byte per cycle sustained while o_rx_stall is low. A byte that yields a result
// reaches the result port through the queue write and then the output reg.
// Rate is set by the front's byte-wide CRC update and the four-entry queue.
// o_rx_stall rises only when the queue is full; it is a registered-count decode.
// Reset is synchronous, active low: hunting, empty sync run, queue empty,
// max_payload_len = 1024. Config is always ready.
// Depends on shcd_pkg, shcd_front, shcd_queue, shcd_back.
module sync_header_crc_frame_deframer #(
    parameter int SYNC_LEN = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // rx byte channel
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    // result channel
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_device_type,
    output logic [31:0] o_device_id,
    output logic [15:0] o_command_id,
    output logic [15:0] o_message_id,
    output logic [15:0] o_payload_len,
    output logic [15:0] o_received_crc,
    output logic        o_frame_last,
    // config write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_max_payload_len
);

    logic              cfg_write;
    logic [15:0]       r_max_payload_len;
    logic              rx_beat;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_nonempty;
    shcd_pkg::t_entry  push_entry;
    shcd_pkg::t_entry  head_entry;
    shcd_pkg::t_hdr    res_hdr;

    // config register; the user must write it only while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload_len <= shcd_pkg::MAX_LEN_RESET;
        end else if (cfg_write) begin
            r_max_payload_len <= i_cfg_max_payload_len;
        end
    end

    assign o_rx_stall = q_full;
    assign rx_beat    = i_rx_valid && !q_full;

    // front: hunt, parse, CRC; classifies each accepted byte that yields a result
    shcd_front #(
        .SYNC_LEN (SYNC_LEN)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (rx_beat),
        .i_byte    (i_rx_byte),
        .i_max_len (r_max_payload_len),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    // decouples front from result back-pressure
    shcd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_entry    (push_entry),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (head_entry)
    );

    // back: verdict and output register
    shcd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_nonempty),
        .i_entry        (head_entry),
        .o_pop          (pop),
        .i_stall        (i_res_stall),
        .o_valid        (o_res_valid),
        .o_result_kind  (o_result_kind),
        .o_payload_byte (o_payload_byte),
        .o_hdr          (res_hdr),
        .o_received_crc (o_received_crc),
        .o_frame_last   (o_frame_last)
    );

    assign o_device_type = res_hdr.device_type;
    assign o_device_id   = res_hdr.device_id;
    assign o_command_id  = res_hdr.command_id;
    assign o_message_id  = res_hdr.message_id;
    assign o_payload_len = res_hdr.payload_len;

endmodule

@@ hw/rtl/shcd_checker.sv @@
// shcd_checker: port-level assertions for the deframer, bound to the top level.
// Depends on shcd_pkg and sync_header_crc_frame_deframer.
module shcd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_res_valid,
    input logic        i_res_stall,
    input logic [1:0]  o_result_kind,
    input logic [7:0]  o_payload_byte,
    input logic [15:0] o_received_crc,
    input logic        o_frame_last
);

    // closing beats and only those carry frame_last
    a_last_matches_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_frame_last == (o_result_kind != shcd_pkg::KIND_PAYLOAD)))
        else $error("frame_last disagrees with result kind");

    // no CRC shown on payload or length-error beats, no byte on closing beats
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_result_kind == shcd_pkg::KIND_PAYLOAD
                      || o_result_kind == shcd_pkg::KIND_LEN_ERR))
        |-> (o_received_crc == 16'h0000))
        else $error("received_crc not zero on payload or length-error beat");

    a_closing_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_frame_last) |-> (o_payload_byte == 8'h00))
        else $error("payload_byte not zero on closing beat");

    // stalled result beat holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_stall) |=> (o_res_valid && $stable(o_result_kind)
                                          && $stable(o_payload_byte)))
        else $error("stalled result beat changed");

    // reset empties the output
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid right after reset");

endmodule

bind sync_header_crc_frame_deframer shcd_checker u_shcd_checker (.*);

@@ sim/deframe_checker.sv @@
`timescale 1ns / 1ps
// deframe_checker: watches the rx, result and config channels of the deframer, predicts
// every result beat and compares it field by field. Holds deframe_tb_pkg (CRC helper).
// Depends on shcd_pkg for the header struct, kind codes and phase enum.

package deframe_tb_pkg;

    localparam logic [15:0] MODBUS_POLY = 16'hA001;

    // bit-serial form of the reflected Modbus CRC16, one byte, LSB first
    function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc_in,
                                                    input logic [7:0] d);
        logic [15:0] c;
        logic        fb;
        c = crc_in;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ d[k];
            c  = {1'b0, c[15:1]};
            if (fb) begin
                c = c ^ MODBUS_POLY;
            end
        end
        return c;
    endfunction

endpackage

module deframe_checker #(
    parameter int SYNC_LEN = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    input  logic        i_rx_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic [1:0]  i_result_kind,
    input  logic [7:0]  i_payload_byte,
    input  logic [7:0]  i_device_type,
    input  logic [31:0] i_device_id,
    input  logic [15:0] i_command_id,
    input  logic [15:0] i_message_id,
    input  logic [15:0] i_payload_len,
    input  logic [15:0] i_received_crc,
    input  logic        i_frame_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_max_payload_len,
    output int          o_fail_count,
    output int          o_results_due,
    output int          o_rx_beats,
    output int          o_result_beats,
    output int          o_good_frames,
    output int          o_crc_errors,
    output int          o_len_errors
);
    import shcd_pkg::*;
    import deframe_tb_pkg::*;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        t_hdr        hdr;
        logic [15:0] crc;
        logic        last;
    } t_out_beat;

    // mirror of the deframer state
    t_phase      ph;
    logic [2:0]  sync_run;
    logic [15:0] byte_cnt;
    logic [63:0] id_shift;
    logic [7:0]  dev_type;
    logic [15:0] len_reg;
    logic [15:0] crc_acc;
    logic [15:0] crc_rx;
    logic [15:0] max_len;

    t_out_beat frame_results_due[$];
    t_out_beat new_beat;
    t_out_beat want;

    int fail_count   = 0;
    int rx_beats     = 0;
    int result_beats = 0;
    int good_frames  = 0;
    int crc_errors   = 0;
    int len_errors   = 0;
    int due_count    = 0;

    assign o_fail_count   = fail_count;
    assign o_results_due  = due_count;
    assign o_rx_beats     = rx_beats;
    assign o_result_beats = result_beats;
    assign o_good_frames  = good_frames;
    assign o_crc_errors   = crc_errors;
    assign o_len_errors   = len_errors;

    function automatic void back_to_hunt();
        ph       = PH_HUNT;
        sync_run = '0;
        byte_cnt = '0;
    endfunction

    // one received byte; returns 1 when it yields a result beat
    function automatic bit deframe_byte(input logic [7:0] b, output t_out_beat r);
        bit produced;
        produced = 1'b0;
        r        = '0;
        case (ph)
            PH_HEADER: begin
                crc_acc = modbus_crc_step(crc_acc, b);
                if (byte_cnt == 0) begin
                    dev_type = b;
                end else if (byte_cnt <= 8) begin
                    id_shift = {id_shift[55:0], b};
                end else if (byte_cnt == 9) begin
                    len_reg = {b, 8'h00};
                end else begin
                    len_reg[7:0] = b;
                end
                byte_cnt++;
                if (byte_cnt >= HEADER_BYTES) begin
                    byte_cnt = '0;
                    if (len_reg > max_len) begin
                        r.kind   = KIND_LEN_ERR;
                        r.hdr    = {dev_type, id_shift, len_reg};
                        r.last   = 1'b1;
                        produced = 1'b1;
                        back_to_hunt();
                    end else begin
                        ph = (len_reg == 0) ? PH_CRC : PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                crc_acc = modbus_crc_step(crc_acc, b);
                byte_cnt++;
                if (byte_cnt >= len_reg) begin
                    byte_cnt = '0;
                    ph       = PH_CRC;
                end
                r.kind   = KIND_PAYLOAD;
                r.data   = b;
                r.hdr    = {dev_type, id_shift, len_reg};
                produced = 1'b1;
            end
            PH_CRC: begin
                if (byte_cnt == 0) begin
                    crc_rx   = {b, 8'h00};
                    byte_cnt = 16'd1;
                end else begin
                    crc_rx[7:0] = b;
                    r.kind   = (crc_rx == crc_acc) ? KIND_GOOD : KIND_CRC_ERR;
                    r.hdr    = {dev_type, id_shift, len_reg};
                    r.crc    = crc_rx;
                    r.last   = 1'b1;
                    produced = 1'b1;
                    back_to_hunt();
                end
            end
            default: begin
                if (b == SYNC_BYTE) begin
                    sync_run++;
                    if (sync_run >= SYNC_LEN) begin
                        crc_acc = CRC_INIT;
                        repeat (SYNC_LEN) crc_acc = modbus_crc_step(crc_acc, SYNC_BYTE);
                        ph       = PH_HEADER;
                        sync_run = '0;
                        byte_cnt = '0;
                        id_shift = '0;
                        dev_type = '0;
                        len_reg  = '0;
                        crc_rx   = '0;
                    end
                end else begin
                    sync_run = '0;
                end
            end
        endcase
        return produced;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ph       = PH_HUNT;
            sync_run = '0;
            byte_cnt = '0;
            id_shift = '0;
            dev_type = '0;
            len_reg  = '0;
            crc_acc  = CRC_INIT;
            crc_rx   = '0;
            max_len  = MAX_LEN_RESET;
            frame_results_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                max_len = i_cfg_max_payload_len;
            end
            if (i_rx_valid && !i_rx_stall) begin
                rx_beats++;
                if (deframe_byte(i_rx_byte, new_beat)) begin
                    frame_results_due.push_back(new_beat);
                end
            end
            if (i_res_valid && !i_res_stall) begin
                result_beats++;
                if (frame_results_due.size() == 0) begin
                    $error("result beat with nothing expected (kind %0d)", i_result_kind);
                    fail_count++;
                end else begin
                    want = frame_results_due.pop_front();
                    case (want.kind)
                        KIND_GOOD:    good_frames++;
                        KIND_CRC_ERR: crc_errors++;
                        KIND_LEN_ERR: len_errors++;
                        default:      ;
                    endcase
                    check_field("result_kind", want.kind, i_result_kind);
                    check_field("payload_byte", want.data, i_payload_byte);
                    check_field("device_type", want.hdr.device_type, i_device_type);
                    check_field("device_id", want.hdr.device_id, i_device_id);
                    check_field("command_id", want.hdr.command_id, i_command_id);
                    check_field("message_id", want.hdr.message_id, i_message_id);
                    check_field("payload_len", want.hdr.payload_len, i_payload_len);
                    check_field("received_crc", want.crc, i_received_crc);
                    check_field("frame_last", want.last, i_frame_last);
                end
            end
        end
        due_count <= frame_results_due.size();
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for sync_header_crc_frame_deframer; checking lives in
// deframe_checker. Depends on shcd_pkg, deframe_tb_pkg and the deframer RTL.

module tb_top;
    import shcd_pkg::*;
    import deframe_tb_pkg::*;

    localparam int SYNC_LEN = 4;

    // all block inputs start at known values
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        rx_valid   = 1'b0;
    logic [7:0]  rx_byte    = '0;
    logic        res_stall  = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic [15:0] cfg_data   = '0;

    logic        rx_stall;
    logic        res_valid;
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  device_type;
    logic [31:0] device_id;
    logic [15:0] command_id;
    logic [15:0] message_id;
    logic [15:0] payload_len;
    logic [15:0] received_crc;
    logic        frame_last;
    logic        cfg_ready;

    int fail_count, results_due, rx_beats, result_beats;
    int good_frames, crc_errors, len_errors;

    // traffic shaping knobs, idle and stall in percent of cycles
    int          idle_pct      = 0;
    int          stall_pct     = 0;
    int          hold_requests = 0;
    int          bytes_sent    = 0;
    logic [15:0] max_len_now   = MAX_LEN_RESET;

    always #1 clk = ~clk;

    sync_header_crc_frame_deframer #(
        .SYNC_LEN(SYNC_LEN)
    ) dut (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_rx_valid            (rx_valid),
        .o_rx_stall            (rx_stall),
        .i_rx_byte             (rx_byte),
        .o_res_valid           (res_valid),
        .i_res_stall           (res_stall),
        .o_result_kind         (result_kind),
        .o_payload_byte        (payload_byte),
        .o_device_type         (device_type),
        .o_device_id           (device_id),
        .o_command_id          (command_id),
        .o_message_id          (message_id),
        .o_payload_len         (payload_len),
        .o_received_crc        (received_crc),
        .o_frame_last          (frame_last),
        .i_cfg_valid           (cfg_valid),
        .o_cfg_ready           (cfg_ready),
        .i_cfg_max_payload_len (cfg_data)
    );

    deframe_checker #(
        .SYNC_LEN(SYNC_LEN)
    ) u_checker (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_rx_valid            (rx_valid),
        .i_rx_stall            (rx_stall),
        .i_rx_byte             (rx_byte),
        .i_res_valid           (res_valid),
        .i_res_stall           (res_stall),
        .i_result_kind         (result_kind),
        .i_payload_byte        (payload_byte),
        .i_device_type         (device_type),
        .i_device_id           (device_id),
        .i_command_id          (command_id),
        .i_message_id          (message_id),
        .i_payload_len         (payload_len),
        .i_received_crc        (received_crc),
        .i_frame_last          (frame_last),
        .i_cfg_valid           (cfg_valid),
        .i_cfg_ready           (cfg_ready),
        .i_cfg_max_payload_len (cfg_data),
        .o_fail_count          (fail_count),
        .o_results_due         (results_due),
        .o_rx_beats            (rx_beats),
        .o_result_beats        (result_beats),
        .o_good_frames         (good_frames),
        .o_crc_errors          (crc_errors),
        .o_len_errors          (len_errors)
    );

    // Result side back-pressure. A hold-off request from the stimulus makes this
    // process hold the stall while hold_left counts down; otherwise stall at random.
    int holds_served = 0;
    int hold_left    = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            res_stall <= 1'b0;
        end else if (hold_left > 0) begin
            res_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (holds_served != hold_requests) begin
            holds_served = holds_served + 1;
            hold_left    = 80;
            res_stall <= 1'b1;
        end else begin
            res_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Hard stop in case the block wedges
    initial begin
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // One rx beat: optional idle cycles first, then hold valid until accepted.
    // The byte never changes while stalled.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (rx_stall);
        bytes_sent++;
    endtask

    // Sender goes quiet until every predicted result has left, then a short
    // tail for bytes that are still in flight but produce nothing.
    task automatic wait_drained();
        rx_valid <= 1'b0;
        do @(posedge clk); while (results_due != 0);
        repeat (12) @(posedge clk);
    endtask

    // Only ever called with the block idle
    task automatic set_max_len(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        max_len_now = v;
    endtask

    // Builds sync + big-endian header (+ payload + CRC when the length is legal)
    // and sends it; cut >= 0 truncates after that many bytes.
    task automatic send_frame(input logic [7:0] dtype, input logic [63:0] ids,
                              input logic [15:0] len, input bit corrupt, input int cut);
        logic [7:0]  fr[$];
        logic [15:0] crc;
        int          i;
        repeat (SYNC_LEN) fr.push_back(SYNC_BYTE);
        fr.push_back(dtype);
        for (i = 7; i >= 0; i--) begin
            fr.push_back(ids[i*8 +: 8]);
        end
        fr.push_back(len[15:8]);
        fr.push_back(len[7:0]);
        if (len <= max_len_now) begin
            for (i = 0; i < int'(len); i++) begin
                fr.push_back(8'($urandom));
            end
            crc = CRC_INIT;
            foreach (fr[j]) begin
                crc = modbus_crc_step(crc, fr[j]);
            end
            if (corrupt) begin
                crc = crc ^ (16'h0001 << $urandom_range(15));
            end
            fr.push_back(crc[15:8]);
            fr.push_back(crc[7:0]);
        end
        for (i = 0; i < fr.size() && (cut < 0 || i < cut); i++) begin
            send_byte(fr[i]);
        end
    endtask

    // device type with the extremes well represented
    function automatic logic [7:0] pick_type();
        case ($urandom_range(7))
            0:       return 8'hFF;
            1:       return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly well-formed frames with random content; some noise bytes,
    // truncated frames, bad CRCs and oversize lengths mixed in.
    task automatic random_traffic(input int budget);
        int          start;
        int          roll;
        int          cut;
        int          cap;
        logic [15:0] len;
        bit          corrupt;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                repeat ($urandom_range(6, 1)) begin
                    send_byte(($urandom_range(5) == 0) ? SYNC_BYTE : 8'($urandom));
                end
            end else begin
                cap = (max_len_now < 32) ? int'(max_len_now) : 32;
                if (max_len_now != 16'hFFFF && $urandom_range(99) < 12) begin
                    len = 16'($urandom_range(65535, int'(max_len_now) + 1));
                end else if ($urandom_range(6) == 0) begin
                    len = '0;
                end else begin
                    len = 16'($urandom_range(cap, 0));
                end
                cut     = (roll < 16) ? $urandom_range(SYNC_LEN + 12, SYNC_LEN + 1) : -1;
                corrupt = ($urandom_range(99) < 20);
                send_frame(pick_type(), {$urandom, $urandom}, len, corrupt, cut);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, default limit of 1024.
        // Broken sync run, then five 0xFF in a row: the fifth is the device type.
        send_byte(SYNC_BYTE);
        send_byte(SYNC_BYTE);
        send_byte(8'h00);
        send_frame(8'hFF, '1, 16'd0, 1'b0, -1);
        // oversize length with all-zero type and ids, then a short frame with a bad CRC
        send_frame(8'h00, '0, 16'hFFFF, 1'b0, -1);
        send_frame(8'h5A, {$urandom, $urandom}, 16'd2, 1'b1, -1);
        wait_drained();

        // Lowest limit: only empty payloads get through
        set_max_len(16'd0);
        send_frame(pick_type(), {$urandom, $urandom}, 16'd0, 1'b0, -1);
        send_frame(pick_type(), {$urandom, $urandom}, 16'd1, 1'b0, -1);
        wait_drained();

        // Highest limit, no idling on either side
        set_max_len(16'hFFFF);
        random_traffic(275);
        wait_drained();

        // Sender gaps; one mid-phase pause until everything has drained
        set_max_len(16'($urandom_range(40, 8)));
        idle_pct = 54;
        random_traffic(140);
        wait_drained();
        random_traffic(140);
        wait_drained();

        // Receiver stalls; a long hold-off while a 20-byte payload keeps coming,
        // so the internal queue fills and rx is stalled
        set_max_len(16'($urandom_range(60, 24)));
        idle_pct  = 0;
        stall_pct = 54;
        hold_requests++;
        send_frame(pick_type(), {$urandom, $urandom}, 16'd20, 1'b0, -1);
        random_traffic(250);
        wait_drained();

        // Both sides idling
        set_max_len(16'($urandom_range(40, 1)));
        idle_pct  = 34;
        stall_pct = 34;
        random_traffic(275);
        wait_drained();

        $display("Sent %0d rx beats, checked %0d result beats: %0d good, %0d CRC mismatch, %0d oversize",
                 rx_beats, result_beats, good_frames, crc_errors, len_errors);
        $display("Limits 1024, 0, 65535 and three small ones; four gap/stall mixes plus a hold-off");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
